// ===== src/rig_pkg.sv =====
`default_nettype none
package rig_pkg;

	// Width of the radix field
	localparam int RADIX_BITS = 6;
	// Dividend bits retired per divider cycle
	localparam int STEP_BITS = 8;
	// Default field widths
	localparam int INDEX_BITS_DEF = 31;
	localparam int FRAC_BITS_DEF = 32;

	// Divider steps per division. The dividend is the wider of the index and
	// {digit, fraction}, rounded up to whole steps.
	function automatic int div_steps(input int index_bits, input int frac_bits);
		int w;
		begin
			w = (index_bits > frac_bits + RADIX_BITS) ? index_bits : frac_bits + RADIX_BITS;
			return (w + STEP_BITS - 1) / STEP_BITS;
		end
	endfunction

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_EXT,
		ST_EXT_WB,
		ST_READ,
		ST_LOAD,
		ST_HDIV,
		ST_FIN
	} rig_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;      // latch index and radix, clear accumulator and count
		logic div_load_idx; // divider takes the index as dividend
		logic div_load_acc; // divider takes {digit, accumulator} as dividend
		logic div_step;     // one divider step
		logic ext_done;     // push remainder digit, index takes the quotient
		logic rd_req;       // pop: read the top digit
		logic acc_done;     // accumulator takes the quotient
		logic out_load;     // result into the output register
	} rig_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic radix_ok;
		logic idx_zero;
		logic cnt_zero;
		logic out_free;
	} rig_sts_t;

endpackage
`default_nettype wire

// ===== src/rig_ram.sv =====
`default_nettype none
module rig_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/rig_ctrl.sv =====
`default_nettype none
module rig_ctrl
	import rig_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output      logic     s_tready,
	input  wire rig_sts_t sts,
	output      rig_cmd_t cmd
);

	localparam int STEPS = div_steps(INDEX_BITS, FRAC_BITS);
	localparam int CW    = $clog2(STEPS);

	rig_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          cnt_last;

	assign cnt_last = (cnt_q == CW'(STEPS - 1));

	// State register and divider cycle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.radix_ok && !sts.idx_zero) state_d = ST_EXT;
				else if (sts.cnt_zero)             state_d = ST_FIN;
				else                               state_d = ST_READ;
			end
			ST_EXT: begin
				if (cnt_last) state_d = ST_EXT_WB;
			end
			ST_EXT_WB: state_d = ST_CHECK;
			ST_READ:   state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_HDIV;
			ST_HDIV: begin
				if (cnt_last) state_d = sts.cnt_zero ? ST_FIN : ST_READ;
			end
			ST_FIN: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_CHECK: begin
				cmd.div_load_idx = sts.radix_ok && !sts.idx_zero;
			end
			ST_EXT:    cmd.div_step     = 1'b1;
			ST_EXT_WB: cmd.ext_done     = 1'b1;
			ST_READ:   cmd.rd_req       = 1'b1;
			ST_LOAD:   cmd.div_load_acc = 1'b1;
			ST_HDIV: begin
				cmd.div_step = 1'b1;
				cmd.acc_done = cnt_last;
			end
			ST_FIN:    cmd.out_load     = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/rig_dp.sv =====
`default_nettype none
module rig_dp
	import rig_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [INDEX_BITS-1:0] in_index,
	input  wire logic [RADIX_BITS-1:0] in_radix,
	input  wire rig_cmd_t              cmd,
	output      rig_sts_t              sts,
	input  wire logic                  out_ready,
	output      logic                  out_valid,
	output      logic [FRAC_BITS-1:0]  out_fraction
);

	localparam int PW = div_steps(INDEX_BITS, FRAC_BITS) * STEP_BITS;
	localparam int AW = $clog2(INDEX_BITS);
	localparam int NW = $clog2(INDEX_BITS + 1);

	logic [INDEX_BITS-1:0] idx_q;
	logic [RADIX_BITS-1:0] radix_q;
	logic [FRAC_BITS-1:0]  acc_q;
	logic [NW-1:0]         cnt_q;
	logic [PW-1:0]         quo_q, quo_d;
	logic [RADIX_BITS-1:0] rem_q, rem_d;
	logic [RADIX_BITS-1:0] digit_rd;
	logic [NW-1:0]         cnt_dec;

	assign cnt_dec = cnt_q - 1'b1;

	// Digit stack, deepest for radix two
	rig_ram #(
		.WIDTH (RADIX_BITS),
		.DEPTH (INDEX_BITS)
	) u_digits (
		.clk   (clk),
		.we    (cmd.ext_done),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_q),
		.re    (cmd.rd_req),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (digit_rd)
	);

	// Restoring division, STEP_BITS quotient bits per cycle while div_step is set; quotient bits
	// shift in at the bottom as dividend bits leave at the top
	always_comb begin
		logic [RADIX_BITS:0] r;
		logic [PW-1:0]       q;
		r = {1'b0, rem_q};
		q = quo_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[RADIX_BITS-1:0], q[PW-1]};
			q = {q[PW-2:0], 1'b0};
			if (r >= {1'b0, radix_q}) begin
				r    = r - {1'b0, radix_q};
				q[0] = 1'b1;
			end
		end
		rem_d = r[RADIX_BITS-1:0];
		quo_d = q;
	end

	// Operand, accumulator and divider registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q   <= in_index;
			radix_q <= in_radix;
			acc_q   <= '0;
		end
		if (cmd.div_load_idx) begin
			quo_q <= PW'(idx_q);
			rem_q <= '0;
		end else if (cmd.div_load_acc) begin
			quo_q <= PW'({digit_rd, acc_q});
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
		if (cmd.ext_done) begin
			idx_q <= quo_q[INDEX_BITS-1:0];
		end
		if (cmd.div_step && cmd.acc_done) begin
			acc_q <= quo_d[FRAC_BITS-1:0];
		end
		if (cmd.out_load) begin
			out_fraction <= acc_q;
		end
	end

	// Digit count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.ext_done) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.rd_req) begin
				cnt_q <= cnt_dec;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.radix_ok = (radix_q >= RADIX_BITS'(2));
	assign sts.idx_zero = (idx_q == '0);
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== src/radical_inverse_generator.sv =====
`default_nettype none
// Halton radical inverse: mirrors the radix digits of a sample index about the
// radix point and returns floor(2^FRAC_BITS * value) as an unsigned fraction.
// Radix below two, or index zero, gives zero. Items are handled one at a time;
// one divider (STEP_BITS quotient bits a cycle while it steps) does both the
// digit extraction and the Horner steps, with the digits held in a small
// stack RAM. A finished result sits in the output register while the next
// beat is taken.
module radical_inverse_generator
	import rig_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                                                 clk,
	input  wire logic                                                 arst_n,
	input  wire logic                                                 s_tvalid,
	output      logic                                                 s_tready,
	// index [INDEX_BITS-1:0], radix [INDEX_BITS+5:INDEX_BITS], zero fill
	input  wire logic [((INDEX_BITS + RADIX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output      logic                                                 m_tvalid,
	input  wire logic                                                 m_tready,
	// fraction [FRAC_BITS-1:0], zero fill
	output      logic [((FRAC_BITS + 7) / 8) * 8 - 1:0]               m_tdata
);

	localparam int OW = ((FRAC_BITS + 7) / 8) * 8;

	rig_cmd_t             cmd;
	rig_sts_t             sts;
	logic [FRAC_BITS-1:0] fraction;

	rig_ctrl #(
		.INDEX_BITS (INDEX_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rig_dp #(
		.INDEX_BITS (INDEX_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_index     (s_tdata[INDEX_BITS-1:0]),
		.in_radix     (s_tdata[INDEX_BITS +: RADIX_BITS]),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_fraction (fraction)
	);

	assign m_tdata = OW'(fraction);

endmodule
`default_nettype wire
